/* src/drrip_pkg.sv */
// shared constants and types for the drrip stream bypass replacement unit
`timescale 1ns / 1ps

package drrip_pkg;

  // default geometry
  localparam int DEF_NUM_SETS     = 2048;
  localparam int DEF_NUM_WAYS     = 16;
  localparam int DEF_LEADER_COUNT = 32;

  // fixed port field widths
  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int ADDR_W   = 64;
  localparam int CHANCE_W = 5;
  localparam int VIC_W    = 5;

  // operation codes
  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // re-reference values
  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] RRPV_LONG    = 2'd2;
  localparam logic [1:0] RRPV_MAX     = 2'd3;
  localparam logic [1:0] STRIDE_SAT   = 2'd3;

  // dueling selector
  localparam int         SEL_W   = 10;
  localparam logic [9:0] SEL_MID = 10'd512;
  localparam logic [9:0] SEL_MAX = 10'd1023;

  // per-set stride detector entry
  typedef struct packed {
    logic [ADDR_W-1:0] prev_address;
    logic [ADDR_W-1:0] prev_stride;
    logic [1:0]        count;
  } stride_entry_t;

endpackage

/* src/drrip_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module drrip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/drrip_stream_bypass_replacement_unit.sv */
// drrip replacement engine with per-set stride bypass, top level
//
// channel | dir | fields (tdata / tuser)
// s_*     | in  | set_index, way_index, phys_address, was_hit, chance / opcode
// m_*     | out | victim_way / victim_valid
//
// each item first reads the set's rrpv row and stride entry, then modifies and
// writes them back (the stride entry only on an update); the memories' registered
// read sets this. after reset a clearing pass writes every set; s_tready
// stays low until it ends, and again while an item is at work.
// a result waiting on m_tready holds the write-back cycle; a new item is taken
// while a finished result still waits in the output register.
`timescale 1ns / 1ps

module drrip_stream_bypass_replacement_unit
  import drrip_pkg::*;
#(
  parameter int NUM_SETS     = DEF_NUM_SETS,
  parameter int NUM_WAYS     = DEF_NUM_WAYS,
  parameter int LEADER_COUNT = DEF_LEADER_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // set_index[10:0], way_index[14:11], phys_address[78:15], was_hit[79],
  // chance[84:80], zero pad[87:85]
  input  logic [87:0] s_tdata,
  // opcode[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // victim_way[3:0], zero pad[7:4]
  output logic [7:0]  m_tdata,
  // victim_valid[0]
  output logic [0:0]  m_tuser
);

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int ROW_W   = 2 * NUM_WAYS;
  localparam int ENTRY_W = $bits(stride_entry_t);
  localparam int RED_W   = 22;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0]          state;
  logic [SET_W-1:0]    clr_addr;
  logic [SEL_W-1:0]    duel_selector;

  // captured item
  logic                op_q;
  logic [SET_W-1:0]    set_q;
  logic [WAY_IN_W-1:0] way_q;
  logic [ADDR_W-1:0]   addr_q;
  logic                hit_q;
  logic [CHANCE_W-1:0] chance_q;

  logic                out_valid;
  logic [VIC_W-1:0]    out_way;
  logic                out_flag;

  logic                accept;
  logic                go;
  logic [SET_W-1:0]    set_red;

  logic [ROW_W-1:0]    rrpv_rd;
  logic [ROW_W-1:0]    rrpv_new;
  logic [ENTRY_W-1:0]  stride_rd_bits;
  stride_entry_t       stride_rd;
  stride_entry_t       stride_new;

  logic                rrpv_we;
  logic [SET_W-1:0]    rrpv_waddr;
  logic [ROW_W-1:0]    rrpv_wdata;
  logic                stride_we;
  logic [ENTRY_W-1:0]  stride_wdata;

  logic [1:0]          top;
  logic [VIC_W-1:0]    victim;
  logic [ADDR_W-1:0]   stride;
  logic [1:0]          cnt_next;
  logic                srrip_lead;
  logic                brrip_lead;
  logic                bimodal;
  logic [1:0]          ins;
  logic [1:0]          upd_val;
  logic                way_ok;
  logic [SEL_W-1:0]    duel_selector_next;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign go       = (state == ST_RUN) && (!out_valid || m_tready);

  // reduce the set index modulo NUM_SETS by shifted compare and subtract (complete for NUM_SETS of 64 or more)
  always_comb begin
    logic [RED_W-1:0] r;
    r = RED_W'(s_tdata[SET_IN_W-1:0]);
    for (int k = 4; k >= 0; k--) begin
      if (r >= (RED_W'(NUM_SETS) << k)) begin
        r = r - (RED_W'(NUM_SETS) << k);
      end
    end
    set_red = r[SET_W-1:0];
  end

  // control and item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      duel_selector <= SEL_MID;
      out_valid     <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SET_W'(NUM_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
      if (go) begin
        out_valid     <= 1'b1;
        duel_selector <= duel_selector_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= s_tuser[0];
      set_q    <= set_red;
      way_q    <= s_tdata[14:11];
      addr_q   <= s_tdata[78:15];
      hit_q    <= s_tdata[79];
      chance_q <= s_tdata[84:80];
    end
    if (go) begin
      out_way  <= (op_q == OP_VICTIM) ? victim : '0;
      out_flag <= (op_q == OP_VICTIM);
    end
  end

  // victim search: highest value in the row, first way holding it
  always_comb begin
    logic any3, any2, any1;
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      any3 = any3 | (rrpv_rd[2*i +: 2] == 2'd3);
      any2 = any2 | (rrpv_rd[2*i +: 2] == 2'd2);
      any1 = any1 | (rrpv_rd[2*i +: 2] == 2'd1);
    end
    top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    victim = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (rrpv_rd[2*i +: 2] == top) begin
        victim = VIC_W'(i);
      end
    end
  end

  // stride detector
  assign stride_rd = stride_entry_t'(stride_rd_bits);
  assign stride    = addr_q - stride_rd.prev_address;

  always_comb begin
    cnt_next = stride_rd.count;
    if (stride_rd.prev_address != '0) begin
      if (stride == stride_rd.prev_stride) begin
        if (stride_rd.count != STRIDE_SAT) begin
          cnt_next = stride_rd.count + 2'd1;
        end
      end else if (stride_rd.count != 2'd0) begin
        cnt_next = stride_rd.count - 2'd1;
      end
    end
    stride_new.prev_address = addr_q;
    stride_new.prev_stride  = stride;
    stride_new.count        = cnt_next;
  end

  // insertion policy and dueling selector
  assign srrip_lead = set_q < SET_W'(LEADER_COUNT);
  assign brrip_lead = set_q >= SET_W'(NUM_SETS - LEADER_COUNT);
  assign bimodal    = srrip_lead ? 1'b0 : (brrip_lead ? 1'b1 : (duel_selector >= SEL_MID));
  assign way_ok     = 6'(way_q) < 6'(NUM_WAYS);

  always_comb begin
    if (bimodal) begin
      ins = (chance_q == '0) ? RRPV_NEAR : RRPV_MAX;
    end else begin
      ins = RRPV_LONG;
    end
    if (cnt_next == STRIDE_SAT) begin
      ins = RRPV_MAX;
    end
    upd_val = hit_q ? RRPV_NEAR : ins;

    duel_selector_next = duel_selector;
    if ((op_q == OP_UPDATE) && !hit_q) begin
      if (srrip_lead && (duel_selector != SEL_MAX)) begin
        duel_selector_next = duel_selector + 1'b1;
      end else if (brrip_lead && (duel_selector != '0)) begin
        duel_selector_next = duel_selector - 1'b1;
      end
    end
  end

  // new rrpv row: age for victim, single-way write for update
  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (op_q == OP_VICTIM) begin
        rrpv_new[2*i +: 2] = rrpv_rd[2*i +: 2] + (RRPV_MAX - top);
      end else if (way_ok && (6'(way_q) == 6'(i))) begin
        rrpv_new[2*i +: 2] = upd_val;
      end else begin
        rrpv_new[2*i +: 2] = rrpv_rd[2*i +: 2];
      end
    end
  end

  // memory write ports, shared with the clearing pass
  always_comb begin
    if (state == ST_CLEAR) begin
      rrpv_we      = 1'b1;
      rrpv_waddr   = clr_addr;
      rrpv_wdata   = '1;
      stride_we    = 1'b1;
      stride_wdata = '0;
    end else begin
      rrpv_we      = go;
      rrpv_waddr   = set_q;
      rrpv_wdata   = rrpv_new;
      stride_we    = go && (op_q == OP_UPDATE);
      stride_wdata = ENTRY_W'(stride_new);
    end
  end

  drrip_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_rrpv_ram (
    .clk   (clk),
    .we    (rrpv_we),
    .waddr (rrpv_waddr),
    .wdata (rrpv_wdata),
    .re    (accept),
    .raddr (set_red),
    .rdata (rrpv_rd)
  );

  drrip_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SETS)
  ) u_stride_ram (
    .clk   (clk),
    .we    (stride_we),
    .waddr (rrpv_waddr),
    .wdata (stride_wdata),
    .re    (accept),
    .raddr (set_red),
    .rdata (stride_rd_bits)
  );

  // output register
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_way[3:0]};
  assign m_tuser  = out_flag;

endmodule

/* src/drrip_checker.sv */
// port-level checker for the drrip stream bypass replacement unit, with bind
`timescale 1ns / 1ps

module drrip_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [87:0] s_tdata,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [0:0]  m_tuser
);

  // no result comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // one item in flight: no new item the cycle after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item taken while the previous one is still at work");

  // update answers carry way zero, and the pad bits stay zero
  a_update_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
    else $error("update result with nonzero way");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:4] == 4'd0))
    else $error("victim way beyond four bits");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind drrip_stream_bypass_replacement_unit drrip_checker u_drrip_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
